@@ rtl/tkns_pkg.sv @@
// Shared types and constants of the top-k negative score selector.
`timescale 1ns / 1ps

package tkns_pkg;

  localparam int MAX_PICK   = 16;
  localparam int INDEX_BITS = 16;
  localparam int SCORE_BITS = 32;
  localparam int COUNT_BITS = 5;
  localparam int RANK_BITS  = 4;
  localparam int PADDR_BITS = 3;
  localparam int PDATA_BITS = 32;

  // Register indexes of the configuration port
  localparam logic [PADDR_BITS-3:0] REG_PICK_COUNT = 1'b0;

  localparam logic [COUNT_BITS-1:0] PICK_COUNT_RESET = COUNT_BITS'(MAX_PICK);

  // One candidate word
  typedef struct packed {
    logic [INDEX_BITS-1:0]        point_index;
    logic signed [SCORE_BITS-1:0] score;
    logic                         last_item;
  } in_word_t;

  // One result word
  typedef struct packed {
    logic [RANK_BITS-1:0]         rank;
    logic [INDEX_BITS-1:0]        chosen_index;
    logic signed [SCORE_BITS-1:0] chosen_score;
    logic [COUNT_BITS-1:0]        selected_count;
    logic                         entry_valid;
    logic                         last_result;
  } out_word_t;

  // One kept list entry
  typedef struct packed {
    logic signed [SCORE_BITS-1:0] score;
    logic [INDEX_BITS-1:0]        index;
  } entry_t;

endpackage

@@ rtl/tkns_list.sv @@
// Sorted insertion list: compares a new candidate against every slot at once.
`timescale 1ns / 1ps

module tkns_list (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 ins_i,
  input  tkns_pkg::in_word_t                   word_i,
  input  logic [tkns_pkg::COUNT_BITS-1:0]      k_i,
  input  logic                                 clear_i,
  output tkns_pkg::entry_t                     entries_o [tkns_pkg::MAX_PICK],
  output logic [tkns_pkg::MAX_PICK-1:0]        filled_o
);

  tkns_pkg::entry_t                entries_q [tkns_pkg::MAX_PICK];
  tkns_pkg::entry_t                entries_d [tkns_pkg::MAX_PICK];
  logic [tkns_pkg::MAX_PICK-1:0]   filled_q;
  logic [tkns_pkg::MAX_PICK-1:0]   filled_d;
  logic [tkns_pkg::MAX_PICK-1:0]   lt;
  tkns_pkg::entry_t                new_entry;

  assign new_entry.score = word_i.score;
  assign new_entry.index = word_i.point_index;

  // Find the slots the new word goes in front of; sorted list makes this a thermometer
  always_comb begin
    for (int i = 0; i < tkns_pkg::MAX_PICK; i++) begin
      lt[i] = (tkns_pkg::COUNT_BITS'(i) < k_i) &&
              (!filled_q[i] || (word_i.score < entries_q[i].score));
    end
  end

  // Insert at the first such slot, shift the rest down, drop slots past the count
  always_comb begin
    for (int i = 0; i < tkns_pkg::MAX_PICK; i++) begin
      entries_d[i] = entries_q[i];
      filled_d[i]  = filled_q[i];
      if (clear_i) begin
        filled_d[i] = 1'b0;
      end else if (ins_i) begin
        if (!(tkns_pkg::COUNT_BITS'(i) < k_i)) begin
          filled_d[i] = 1'b0;
        end else if (lt[i]) begin
          if (i > 0 && lt[(i > 0) ? i - 1 : 0]) begin
            entries_d[i] = entries_q[(i > 0) ? i - 1 : 0];
            filled_d[i]  = filled_q[(i > 0) ? i - 1 : 0];
          end else begin
            entries_d[i] = new_entry;
            filled_d[i]  = 1'b1;
          end
        end
      end
    end
  end

  // Hold filled marks under reset; entries need none
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filled_q <= '0;
    end else begin
      filled_q <= filled_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entries_q <= entries_d;
  end

  assign entries_o = entries_q;
  assign filled_o  = filled_q;

endmodule

@@ rtl/tkns_report.sv @@
// Report sequencer: snapshots the list and emits qualifying entries one a cycle.
`timescale 1ns / 1ps

module tkns_report (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             load_i,
  input  tkns_pkg::entry_t                 entries_i [tkns_pkg::MAX_PICK],
  input  logic [tkns_pkg::MAX_PICK-1:0]    filled_i,
  input  logic [tkns_pkg::COUNT_BITS-1:0]  k_i,
  output logic                             active_o,
  output logic                             result_valid_o,
  output tkns_pkg::out_word_t              out_word_o
);

  tkns_pkg::entry_t                  snap_q [tkns_pkg::MAX_PICK];
  tkns_pkg::entry_t                  snap_d [tkns_pkg::MAX_PICK];
  logic [tkns_pkg::COUNT_BITS-1:0]   n_q;
  logic [tkns_pkg::COUNT_BITS-1:0]   n_d;
  logic [tkns_pkg::RANK_BITS-1:0]    cnt_q;
  logic [tkns_pkg::RANK_BITS-1:0]    cnt_d;
  logic                              active_q;
  logic                              active_d;
  logic [tkns_pkg::MAX_PICK-1:0]     qual;
  logic                              final_word;

  // Cut the report at the first slot that is empty, past the count or positive
  always_comb begin
    n_d = tkns_pkg::COUNT_BITS'(tkns_pkg::MAX_PICK);
    for (int i = tkns_pkg::MAX_PICK - 1; i >= 0; i--) begin
      qual[i] = filled_i[i] && (tkns_pkg::COUNT_BITS'(i) < k_i) &&
                (entries_i[i].score[tkns_pkg::SCORE_BITS-1] || (entries_i[i].score == '0));
      if (!qual[i]) begin
        n_d = tkns_pkg::COUNT_BITS'(i);
      end
    end
  end

  assign final_word = (n_q == '0) ||
                      ({1'b0, cnt_q} + tkns_pkg::COUNT_BITS'(1) == n_q);

  // Load the snapshot, then advance one entry a cycle until the final word
  always_comb begin
    snap_d   = snap_q;
    cnt_d    = cnt_q;
    active_d = active_q;
    if (load_i) begin
      snap_d   = entries_i;
      cnt_d    = '0;
      active_d = 1'b1;
    end else if (active_q) begin
      for (int i = 0; i < tkns_pkg::MAX_PICK - 1; i++) begin
        snap_d[i] = snap_q[i + 1];
      end
      cnt_d = cnt_q + tkns_pkg::RANK_BITS'(1);
      if (final_word) begin
        active_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      cnt_q    <= '0;
      n_q      <= '0;
    end else begin
      active_q <= active_d;
      cnt_q    <= cnt_d;
      if (load_i) begin
        n_q <= n_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    snap_q <= snap_d;
  end

  // Drive the result word; an empty report gives one invalid word
  always_comb begin
    out_word_o = '0;
    out_word_o.last_result = final_word;
    if (n_q != '0) begin
      out_word_o.rank           = cnt_q;
      out_word_o.chosen_index   = snap_q[0].index;
      out_word_o.chosen_score   = snap_q[0].score;
      out_word_o.selected_count = n_q;
      out_word_o.entry_valid    = 1'b1;
    end
  end

  assign result_valid_o = active_q;
  assign active_o       = active_q;

endmodule

@@ rtl/top_k_negative_score_selector.sv @@
// Top level: configuration port, candidate intake and report of the selector.
// A word without last_item is taken while busy is low, one word per cycle.
// A last word keeps busy high through the run-end mark and the report of its n
// qualifying entries (one word if none); results follow the snapshot, one per cycle.
// Results cannot be stalled by the receiver. Throughput is set by the report pass.
// Reset empties the list and sets pick_count to 16.
`timescale 1ns / 1ps

module top_k_negative_score_selector (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [tkns_pkg::PADDR_BITS-1:0]  paddr,
  input  logic [tkns_pkg::PDATA_BITS-1:0]  pwdata,
  output logic [tkns_pkg::PDATA_BITS-1:0]  prdata,
  output logic                             pready,
  input  logic                             start,
  output logic                             busy,
  input  tkns_pkg::in_word_t               in_word_i,
  output logic                             result_valid_o,
  output tkns_pkg::out_word_t              out_word_o
);

  logic [tkns_pkg::COUNT_BITS-1:0] pick_count_q;
  logic [tkns_pkg::COUNT_BITS-1:0] k_eff;
  logic                            pend_q;
  logic                            accept;
  logic                            active;
  logic                            reg_sel;
  tkns_pkg::entry_t                entries [tkns_pkg::MAX_PICK];
  logic [tkns_pkg::MAX_PICK-1:0]   filled;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[tkns_pkg::PADDR_BITS-1:2] == tkns_pkg::REG_PICK_COUNT);

  // Write the pick count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pick_count_q <= tkns_pkg::PICK_COUNT_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      pick_count_q <= pwdata[tkns_pkg::COUNT_BITS-1:0];
    end
  end

  assign prdata = reg_sel ? tkns_pkg::PDATA_BITS'(pick_count_q) : '0;

  // Clamp the count into one to the list depth
  always_comb begin
    k_eff = pick_count_q;
    if (pick_count_q == '0) begin
      k_eff = tkns_pkg::COUNT_BITS'(1);
    end else if (pick_count_q > tkns_pkg::COUNT_BITS'(tkns_pkg::MAX_PICK)) begin
      k_eff = tkns_pkg::COUNT_BITS'(tkns_pkg::MAX_PICK);
    end
  end

  assign busy   = pend_q | active;
  assign accept = start & ~busy;

  // Mark a run end for one cycle so the list settles before the snapshot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
    end else begin
      pend_q <= accept & in_word_i.last_item;
    end
  end

  tkns_list u_list (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ins_i     (accept),
    .word_i    (in_word_i),
    .k_i       (k_eff),
    .clear_i   (pend_q),
    .entries_o (entries),
    .filled_o  (filled)
  );

  tkns_report u_report (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .load_i         (pend_q),
    .entries_i      (entries),
    .filled_i       (filled),
    .k_i            (k_eff),
    .active_o       (active),
    .result_valid_o (result_valid_o),
    .out_word_o     (out_word_o)
  );

endmodule

@@ tb/tb_top_k_negative_score_selector.sv @@
// Self-checking testbench of the top-k negative score selector.
`timescale 1ns / 1ps

module tb_top_k_negative_score_selector;
  import tkns_pkg::*;

  localparam int CLK_PERIOD    = 4;
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_CYCLES  = 8;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int RANDOM_WORDS  = 207;

  localparam logic [PADDR_BITS-1:0] PICK_COUNT_ADDR = {REG_PICK_COUNT, 2'b00};
  localparam logic [PADDR_BITS-1:0] SPARE_ADDR      = 3'd4;

  typedef enum logic {ROW_CANDIDATE, ROW_REGISTER} row_kind_e;

  typedef struct {
    row_kind_e              kind;
    logic [PADDR_BITS-1:0]  addr;
    logic [PDATA_BITS-1:0]  data;
    in_word_t               word;
    logic                   typed;
    out_word_t              want;
  } plan_row_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [PADDR_BITS-1:0]  paddr;
  logic [PDATA_BITS-1:0]  pwdata;
  logic [PDATA_BITS-1:0]  prdata;
  logic                   pready;
  logic                   start;
  logic                   busy;
  in_word_t               in_word_i;
  logic                   result_valid_o;
  out_word_t              out_word_o;

  // Shadow of the kept list and the count register
  logic signed [SCORE_BITS-1:0] kept_score [MAX_PICK];
  logic [INDEX_BITS-1:0]        kept_index [MAX_PICK];
  logic                         kept_filled [MAX_PICK];
  logic [COUNT_BITS-1:0]        pick_reg;

  out_word_t   pending_reports [$];
  out_word_t   head_report;
  plan_row_t   plan [$];
  logic [31:0] tie_pool [4];
  int          errors = 0;
  int          cycle_count = 0;

  top_k_negative_score_selector DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .start          (start),
    .busy           (busy),
    .in_word_i      (in_word_i),
    .result_valid_o (result_valid_o),
    .out_word_o     (out_word_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // Insert one candidate into the shadow list; on a last word, queue the report
  function automatic void rank_candidate(in_word_t w, bit keep);
    int        k;
    int        pos;
    int        n;
    int        i;
    out_word_t r;
    k = (pick_reg == 0) ? 1 : ((pick_reg > MAX_PICK) ? MAX_PICK : int'(pick_reg));
    pos = k;
    for (i = 0; i < k; i++) begin
      if (!kept_filled[i] || (w.score < kept_score[i])) begin
        pos = i;
        break;
      end
    end
    if (pos < k) begin
      for (i = k - 1; i > pos; i--) begin
        kept_score[i]  = kept_score[i-1];
        kept_index[i]  = kept_index[i-1];
        kept_filled[i] = kept_filled[i-1];
      end
      kept_score[pos]  = w.score;
      kept_index[pos]  = w.point_index;
      kept_filled[pos] = 1'b1;
    end
    for (i = k; i < MAX_PICK; i++) kept_filled[i] = 1'b0;
    if (!w.last_item) return;
    // Cut the report at the first empty slot or positive score
    n = 0;
    while (n < k && kept_filled[n] && kept_score[n] <= 0) n++;
    if (n == 0) begin
      r = '0;
      r.last_result = 1'b1;
      if (keep) pending_reports.push_back(r);
    end else begin
      for (i = 0; i < n; i++) begin
        r.rank           = RANK_BITS'(i);
        r.chosen_index   = kept_index[i];
        r.chosen_score   = kept_score[i];
        r.selected_count = COUNT_BITS'(n);
        r.entry_valid    = 1'b1;
        r.last_result    = (i == n - 1);
        if (keep) pending_reports.push_back(r);
      end
    end
    for (i = 0; i < MAX_PICK; i++) kept_filled[i] = 1'b0;
  endfunction

  function automatic out_word_t single_report(logic [15:0] idx, logic [31:0] sc, logic valid);
    out_word_t r;
    r                = '0;
    r.chosen_index   = idx;
    r.chosen_score   = sc;
    r.selected_count = COUNT_BITS'(valid);
    r.entry_valid    = valid;
    r.last_result    = 1'b1;
    return r;
  endfunction

  function automatic void plan_candidate(logic [15:0] idx, logic [31:0] sc, logic last);
    plan_row_t row;
    row.kind  = ROW_CANDIDATE;
    row.addr  = '0;
    row.data  = '0;
    row.word  = {idx, sc, last};
    row.typed = 1'b0;
    row.want  = '0;
    plan.push_back(row);
  endfunction

  function automatic void plan_checked(logic [15:0] idx, logic [31:0] sc, out_word_t want);
    plan_row_t row;
    row.kind  = ROW_CANDIDATE;
    row.addr  = '0;
    row.data  = '0;
    row.word  = {idx, sc, 1'b1};
    row.typed = 1'b1;
    row.want  = want;
    plan.push_back(row);
  endfunction

  function automatic void plan_register(logic [PADDR_BITS-1:0] addr, logic [31:0] data);
    plan_row_t row;
    row.kind  = ROW_REGISTER;
    row.addr  = addr;
    row.data  = data;
    row.word  = '0;
    row.typed = 1'b0;
    row.want  = '0;
    plan.push_back(row);
  endfunction

  function automatic int gap_cycles(bit steady);
    return steady ? 0 : $urandom_range(0, 6);
  endfunction

  function automatic logic [COUNT_BITS-1:0] count_choice();
    case ($urandom_range(0, 5))
      0:       return 5'd0;
      1:       return 5'd1;
      2:       return 5'd16;
      3:       return 5'd17;
      4:       return 5'd31;
      default: return COUNT_BITS'($urandom_range(1, MAX_PICK));
    endcase
  endfunction

  // Mostly non-positive scores, with ties from the pool and the odd corner
  function automatic logic [31:0] score_choice();
    case ($urandom_range(0, 11))
      0: return $urandom;
      1: begin
        case ($urandom_range(0, 4))
          0:       return 32'h8000_0000;
          1:       return 32'h7FFF_FFFF;
          2:       return 32'h0000_0000;
          3:       return 32'hFFFF_FFFF;
          default: return 32'h0000_0001;
        endcase
      end
      2, 3:          return tie_pool[$urandom_range(0, 3)];
      4, 5, 6, 7, 8: return 32'h0 - $urandom_range(0, 32'h3FFFF);
      default:       return $urandom_range(1, 32'h3FFFF);
    endcase
  endfunction

  function automatic in_word_t noise_word();
    in_word_t w;
    w.point_index = INDEX_BITS'($urandom);
    w.score       = $urandom;
    w.last_item   = 1'($urandom_range(0, 1));
    return w;
  endfunction

  // Offer one word and hold it until the block takes it
  task automatic send_word(in_word_t w, bit keep);
    in_word_i <= w;
    start     <= 1'b1;
    do @(posedge clk_i); while (busy);
    rank_candidate(w, keep);
  endtask

  task automatic idle_for(int n);
    if (n > 0) begin
      start     <= 1'b0;
      in_word_i <= noise_word();
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Drain the block, then write one register through a setup and an access cycle
  task automatic write_register(logic [PADDR_BITS-1:0] addr, logic [31:0] data);
    start <= 1'b0;
    while (pending_reports.size() != 0 || busy) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (addr == PICK_COUNT_ADDR) pick_reg = data[COUNT_BITS-1:0];
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  // Compare each result word with the oldest expected one
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (pending_reports.size() == 0) begin
        $display("%0t: result word with none expected, expected none, actual %h",
                 $time, out_word_o);
        errors++;
      end else begin
        head_report = pending_reports.pop_front();
        check_field("rank", head_report.rank, out_word_o.rank);
        check_field("chosen_index", head_report.chosen_index, out_word_o.chosen_index);
        check_field("chosen_score", head_report.chosen_score, out_word_o.chosen_score);
        check_field("selected_count", head_report.selected_count, out_word_o.selected_count);
        check_field("entry_valid", head_report.entry_valid, out_word_o.entry_valid);
        check_field("last_result", head_report.last_result, out_word_o.last_result);
      end
    end
  end

  // Stop a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    in_word_t    w;
    int          sent;
    int          run_len;
    int          j;
    bit          steady;
    logic [31:0] d;

    rst_ni    <= 1'b0;
    psel      <= 1'b0;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    paddr     <= '0;
    pwdata    <= '0;
    start     <= 1'b0;
    in_word_i <= '0;
    pick_reg = PICK_COUNT_RESET;
    foreach (kept_filled[i]) kept_filled[i] = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Single-entry runs whose report can be read off directly
    plan_checked(16'd7, 32'hFFFF_0000, single_report(16'd7, 32'hFFFF_0000, 1'b1));
    plan_checked(16'hFFFF, 32'h8000_0000, single_report(16'hFFFF, 32'h8000_0000, 1'b1));
    plan_checked(16'd0, 32'h0, single_report(16'd0, 32'h0, 1'b1));
    plan_checked(16'h1234, 32'h7FFF_FFFF, single_report(16'd0, 32'h0, 1'b0));
    plan_checked(16'd5, 32'h1, single_report(16'd0, 32'h0, 1'b0));
    // Ties keep arrival order
    plan_candidate(16'd1, -32'sd2, 1'b0);
    plan_candidate(16'd2, -32'sd2, 1'b0);
    plan_candidate(16'd3, -32'sd5, 1'b0);
    plan_candidate(16'd4, 32'sd3, 1'b0);
    plan_candidate(16'd5, -32'sd2, 1'b1);
    // A zero count acts as one
    plan_register(PICK_COUNT_ADDR, 32'h0);
    plan_candidate(16'd10, -32'sd3, 1'b0);
    plan_candidate(16'd11, -32'sd9, 1'b0);
    plan_candidate(16'd12, -32'sd9, 1'b1);
    // Shrink the count in the middle of a run
    plan_register(PICK_COUNT_ADDR, 32'd16);
    plan_candidate(16'd20, -32'sd1, 1'b0);
    plan_candidate(16'd21, -32'sd4, 1'b0);
    plan_candidate(16'd22, -32'sd7, 1'b0);
    plan_register(PICK_COUNT_ADDR, 32'd2);
    plan_candidate(16'd23, 32'sd5, 1'b1);
    // Counts above the list depth, upper data bits set
    plan_register(PICK_COUNT_ADDR, 32'hFFFF_FFFF);
    plan_candidate(16'd30, 32'sd100, 1'b0);
    plan_candidate(16'd31, -32'sd100, 1'b1);
    plan_register(PICK_COUNT_ADDR, 32'hFFFF_FFF1);
    plan_candidate(16'd32, 32'h7FFF_FFFF, 1'b0);
    plan_candidate(16'd33, 32'hFFFF_FFFF, 1'b1);
    // A write to an unknown register changes nothing
    plan_register(SPARE_ADDR, 32'h0000_0001);
    plan_candidate(16'd40, -32'sd1, 1'b0);
    plan_candidate(16'd41, -32'sd2, 1'b1);

    foreach (plan[r]) begin
      if (plan[r].kind == ROW_REGISTER) begin
        write_register(plan[r].addr, plan[r].data);
      end else begin
        send_word(plan[r].word, !plan[r].typed);
        if (plan[r].typed) pending_reports.push_back(plan[r].want);
        idle_for(gap_cycles(1'b0));
      end
    end

    // Random runs of candidates, each closed by a last word
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      steady = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 2) == 0) begin
        d = $urandom;
        d[COUNT_BITS-1:0] = count_choice();
        write_register(($urandom_range(0, 9) == 0) ? SPARE_ADDR : PICK_COUNT_ADDR, d);
      end
      foreach (tie_pool[i])
        tie_pool[i] = ($urandom_range(0, 3) == 0) ? 32'h0 : 32'h0 - $urandom_range(1, 32'h20000);
      run_len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 24) : $urandom_range(1, 12);
      for (j = 0; j < run_len; j++) begin
        w.point_index = INDEX_BITS'($urandom);
        w.score       = score_choice();
        w.last_item   = (j == run_len - 1);
        send_word(w, 1'b1);
        sent++;
        if (!w.last_item && $urandom_range(0, 29) == 0) begin
          d = $urandom;
          d[COUNT_BITS-1:0] = count_choice();
          write_register(PICK_COUNT_ADDR, d);
        end else begin
          idle_for(gap_cycles(steady));
        end
      end
    end

    // Wait out the last report
    start <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
